// ----- hw/rtl/dntc_pkg.sv -----
// package for the disciplined ntp timestamp clock
// shared types and fixed constants; no dependencies
`default_nettype none

package dntc_pkg;

    // operation codes carried by each request item
    typedef enum logic [1:0] {
        FUNC_SET_TIME   = 2'd0,
        FUNC_GET_TIME   = 2'd1,
        FUNC_GET_OFFSET = 2'd2,
        FUNC_SET_RATE   = 2'd3
    } func_t;

    // sequencing strobes for the bit-serial conversion units
    typedef struct packed {
        logic load;
        logic step;
    } conv_ctl_t;

    // dividend of the tick conversion is elapsed ticks times 2^32
    localparam int DIVIDEND_W = 64;
    localparam int STEP_W     = 6;

    // ppb arithmetic
    localparam int DIV_W = 30;
    localparam int CORR_W = 22;
    localparam logic [31:0] PPB_SCALE = 32'd1000000000;
    localparam logic signed [31:0] PPB_MAX = 32'sd2000000;
    localparam logic signed [31:0] PPB_MIN = -32'sd2000000;

endpackage

`default_nettype wire

// ----- hw/rtl/dntc_in_if.sv -----
// request channel of the disciplined ntp timestamp clock
// depends on dntc_pkg for the operation code type
`default_nettype none

interface dntc_in_if;
    logic                valid;
    logic                ready;
    dntc_pkg::func_t     func;
    logic [31:0]         count_now;
    logic [31:0]         ref_seconds;
    logic [31:0]         ref_fraction;
    logic signed [31:0]  rate_ppb;

    modport source (
        output valid, func, count_now, ref_seconds, ref_fraction, rate_ppb,
        input  ready
    );
    modport sink (
        input  valid, func, count_now, ref_seconds, ref_fraction, rate_ppb,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/dntc_out_if.sv -----
// response channel of the disciplined ntp timestamp clock
// no dependencies
`default_nettype none

interface dntc_out_if;
    logic                valid;
    logic                ready;
    logic                time_valid;
    logic [31:0]         now_seconds;
    logic [31:0]         now_fraction;
    logic signed [63:0]  offset;
    logic                rate_accepted;

    modport source (
        output valid, time_valid, now_seconds, now_fraction, offset, rate_accepted,
        input  ready
    );
    modport sink (
        input  valid, time_valid, now_seconds, now_fraction, offset, rate_accepted,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/dntc_tick_div.sv -----
// bit-serial restoring divider of elapsed ticks * 2^32 by the tick rate
// depends on dntc_pkg; emits one quotient bit per step, msb first
`default_nettype none

module dntc_tick_div #(
    parameter int unsigned COUNTS_PER_SECOND = 1000000
) (
    input  wire logic                clk,
    input  wire dntc_pkg::conv_ctl_t ctl,
    input  wire logic [31:0]         elapsed,
    output logic                     q_bit
);

    localparam int CPS_W = $clog2(COUNTS_PER_SECOND + 1);
    localparam logic [CPS_W:0] CPS_K = (CPS_W + 1)'(COUNTS_PER_SECOND);

    logic [31:0]      dividend_reg;
    logic [CPS_W-1:0] rem_reg;
    logic [CPS_W:0]   trial;
    logic [CPS_W:0]   diff;

    // next dividend bit enters the partial remainder
    assign trial = {rem_reg, dividend_reg[31]};
    assign q_bit = (trial >= CPS_K);
    assign diff  = trial - CPS_K;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dividend_reg <= elapsed;
            rem_reg      <= '0;
        end
        else if (ctl.step)
        begin
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            rem_reg      <= q_bit ? diff[CPS_W-1:0] : trial[CPS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dntc_ppb_div.sv -----
// bit-serial scaler computing floor(q * 1e9 / divisor) as q arrives msb first
// depends on dntc_pkg; quotient digits 0..3 kept as two bit planes
`default_nettype none

module dntc_ppb_div (
    input  wire logic                      clk,
    input  wire dntc_pkg::conv_ctl_t       ctl,
    input  wire logic                      q_bit,
    input  wire logic [dntc_pkg::DIV_W-1:0] divisor,
    output logic [dntc_pkg::DIVIDEND_W-1:0] scaled
);

    localparam int YW = dntc_pkg::DIVIDEND_W;

    logic [dntc_pkg::DIV_W-1:0] rem_reg;
    logic [31:0]                div1_reg;
    logic [31:0]                div2_reg;
    logic [31:0]                div3_reg;
    logic [YW-1:0]              hi_reg;
    logic [YW-1:0]              lo_reg;
    logic [31:0]                acc;
    logic [31:0]                sub;
    logic [31:0]                rem_full;
    logic [1:0]                 digit;

    // remainder doubles, a set bit of q adds the scale
    assign acc = {1'b0, rem_reg, 1'b0} + (q_bit ? dntc_pkg::PPB_SCALE : 32'd0);

    always_comb
    begin
        priority if (acc >= div3_reg)
        begin
            digit = 2'd3;
            sub   = div3_reg;
        end
        else if (acc >= div2_reg)
        begin
            digit = 2'd2;
            sub   = div2_reg;
        end
        else if (acc >= div1_reg)
        begin
            digit = 2'd1;
            sub   = div1_reg;
        end
        else
        begin
            digit = 2'd0;
            sub   = 32'd0;
        end
    end

    assign rem_full = acc - sub;
    assign scaled   = {hi_reg[YW-2:0], 1'b0} + lo_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            div1_reg <= {2'b00, divisor};
            div2_reg <= {1'b0, divisor, 1'b0};
            div3_reg <= {2'b00, divisor} + {1'b0, divisor, 1'b0};
        end
        else if (ctl.step)
        begin
            rem_reg <= rem_full[dntc_pkg::DIV_W-1:0];
            hi_reg  <= {hi_reg[YW-2:0], digit[1]};
            lo_reg  <= {lo_reg[YW-2:0], digit[0]};
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/disciplined_ntp_timestamp_clock.sv -----
// top level of the disciplined ntp timestamp clock
// depends on dntc_pkg, dntc_in_if, dntc_out_if, dntc_tick_div, dntc_ppb_div
`default_nettype none

// Keeps a 32.32 NTP timestamp anchored at a sample of a free-running 32-bit
// counter ticking COUNTS_PER_SECOND times per second, with a ppb rate
// correction limited to +/-2000000. Each request item carries a counter sample
// and an operation: set_time anchors whole seconds, get_time returns the
// corrected time, get_offset returns reference minus local time as signed
// 32.32, set_rate_correction rebases the anchor and loads a new correction if
// it is in range. Exactly one response item follows every request item. Until
// time is set, time_valid, the now fields and the offset read zero. Items are
// taken one at a time. For set_time and reads before time is set, the item
// goes straight to the finish state. For get_time, get_offset and
// set_rate_correction it passes through states that load the serial units,
// run 64 steps of the bit-serial tick divider and ppb scaler in lockstep, one
// quotient bit per cycle, take the scaled value, add the anchor and finish.
// In finish the response register loads once it is free, and the next request
// item can be accepted in the cycle after that. A waiting response does not
// block the next request item from being accepted; only that item's finish
// waits until the response is taken.

module disciplined_ntp_timestamp_clock #(
    parameter int unsigned COUNTS_PER_SECOND = 1000000
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dntc_in_if.sink    request,
    dntc_out_if.source response
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_SUM,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t                               state_reg;
    logic [dntc_pkg::STEP_W-1:0]          cnt_reg;

    // item being worked on
    dntc_pkg::func_t                      func_reg;
    logic [31:0]                          count_reg;
    logic [31:0]                          rsec_reg;
    logic [31:0]                          rfrac_reg;
    logic signed [dntc_pkg::CORR_W-1:0]   rate_reg;
    logic                                 rate_ok_reg;
    logic [dntc_pkg::DIV_W-1:0]           divisor_reg;
    logic [63:0]                          now_reg;

    // clock state
    logic                                 time_set_reg;
    logic [31:0]                          anchor_count_reg;
    logic [63:0]                          anchor_ts_reg;
    logic signed [dntc_pkg::CORR_W-1:0]   corr_reg;

    // response register
    logic                                 out_valid_reg;
    logic                                 out_time_valid_reg;
    logic [63:0]                          out_now_reg;
    logic signed [63:0]                   out_offset_reg;
    logic                                 out_acc_reg;

    dntc_pkg::conv_ctl_t                  ctl;
    logic                                 accept;
    logic                                 out_take;
    logic                                 out_free;
    logic                                 out_load;
    logic [31:0]                          elapsed;
    logic                                 q_bit;
    logic [dntc_pkg::DIVIDEND_W-1:0]      scaled;
    logic signed [31:0]                   corr_ext;
    logic [31:0]                          div_full;
    logic                                 rate_in_range;
    logic [63:0]                          offset_calc;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_take      = out_valid_reg && response.ready;
    assign out_free      = !out_valid_reg || response.ready;
    // finishing item moves into the response register
    assign out_load      = (state_reg == ST_FINISH) && out_free;

    assign ctl.load = (state_reg == ST_PREP);
    assign ctl.step = (state_reg == ST_RUN);

    // ticks since the anchor, modulo 2^32
    assign elapsed = count_reg - anchor_count_reg;

    // divisor 1e9 - correction always lies in [998000000, 1002000000]
    assign corr_ext = 32'(corr_reg);
    assign div_full = dntc_pkg::PPB_SCALE - $unsigned(corr_ext);

    assign rate_in_range = (request.rate_ppb >= dntc_pkg::PPB_MIN)
                        && (request.rate_ppb <= dntc_pkg::PPB_MAX);

    // reference minus local time, wraps modulo 2^64
    assign offset_calc = {rsec_reg, rfrac_reg} - now_reg;

    dntc_tick_div #(
        .COUNTS_PER_SECOND (COUNTS_PER_SECOND)
    ) u_tick_div (
        .clk     (clk),
        .ctl     (ctl),
        .elapsed (elapsed),
        .q_bit   (q_bit)
    );

    dntc_ppb_div u_ppb_div (
        .clk     (clk),
        .ctl     (ctl),
        .q_bit   (q_bit),
        .divisor (divisor_reg),
        .scaled  (scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            func_reg           <= dntc_pkg::FUNC_SET_TIME;
            count_reg          <= '0;
            rsec_reg           <= '0;
            rfrac_reg          <= '0;
            rate_reg           <= '0;
            rate_ok_reg        <= 1'b0;
            divisor_reg        <= '0;
            now_reg            <= '0;
            time_set_reg       <= 1'b0;
            anchor_count_reg   <= '0;
            anchor_ts_reg      <= '0;
            corr_reg           <= '0;
            out_valid_reg      <= 1'b0;
            out_time_valid_reg <= 1'b0;
            out_now_reg        <= '0;
            out_offset_reg     <= '0;
            out_acc_reg        <= 1'b0;
        end
        else
        begin
            // a new response wins over clearing the one just taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg    <= request.func;
                        count_reg   <= request.count_now;
                        rsec_reg    <= request.ref_seconds;
                        rfrac_reg   <= request.ref_fraction;
                        rate_reg    <= request.rate_ppb[dntc_pkg::CORR_W-1:0];
                        rate_ok_reg <= rate_in_range;
                        divisor_reg <= div_full[dntc_pkg::DIV_W-1:0];
                        priority if (request.func == dntc_pkg::FUNC_SET_TIME)
                        begin
                            now_reg   <= {request.ref_seconds, 32'd0};
                            state_reg <= ST_FINISH;
                        end
                        else if (request.func == dntc_pkg::FUNC_SET_RATE || time_set_reg)
                        begin
                            state_reg <= ST_PREP;
                        end
                        else
                        begin
                            // read before time is set: zero result, nothing to do
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end

                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == dntc_pkg::STEP_W'(dntc_pkg::DIVIDEND_W - 1))
                    begin
                        state_reg <= ST_SUM;
                    end
                end

                ST_SUM:
                begin
                    now_reg   <= scaled;
                    state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    now_reg   <= anchor_ts_reg + now_reg;
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg     <= ST_IDLE;
                        unique case (func_reg)
                            dntc_pkg::FUNC_SET_TIME:
                            begin
                                time_set_reg       <= 1'b1;
                                anchor_count_reg   <= count_reg;
                                anchor_ts_reg      <= now_reg;
                                out_time_valid_reg <= 1'b1;
                                out_now_reg        <= now_reg;
                                out_offset_reg     <= '0;
                                out_acc_reg        <= 1'b0;
                            end
                            dntc_pkg::FUNC_SET_RATE:
                            begin
                                // rebase always, load the correction only if in range
                                anchor_count_reg <= count_reg;
                                anchor_ts_reg    <= now_reg;
                                if (rate_ok_reg)
                                begin
                                    corr_reg <= rate_reg;
                                end
                                out_time_valid_reg <= time_set_reg;
                                out_now_reg        <= time_set_reg ? now_reg : 64'd0;
                                out_offset_reg     <= '0;
                                out_acc_reg        <= rate_ok_reg;
                            end
                            dntc_pkg::FUNC_GET_TIME,
                            dntc_pkg::FUNC_GET_OFFSET:
                            begin
                                out_time_valid_reg <= time_set_reg;
                                out_now_reg        <= time_set_reg ? now_reg : 64'd0;
                                out_offset_reg     <=
                                    (time_set_reg && func_reg == dntc_pkg::FUNC_GET_OFFSET)
                                    ? $signed(offset_calc) : 64'sd0;
                                out_acc_reg        <= 1'b0;
                            end
                        endcase
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.time_valid    = out_time_valid_reg;
    assign response.now_seconds   = out_now_reg[63:32];
    assign response.now_fraction  = out_now_reg[31:0];
    assign response.offset        = out_offset_reg;
    assign response.rate_accepted = out_acc_reg;

    // an invalid time never leaks a timestamp or an offset
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_time_valid_reg |-> out_now_reg == 64'd0 && out_offset_reg == 64'sd0)
        else $error("invalid time with nonzero result");

    // stored correction stays within the ppb limits
    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        corr_ext >= dntc_pkg::PPB_MIN && corr_ext <= dntc_pkg::PPB_MAX)
        else $error("rate correction out of limits");

    // serial conversion always starts right after the units are loaded
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && cnt_reg == '0 |-> $past(state_reg) == ST_PREP)
        else $error("conversion started without load");

    // once set, time stays set
    a_time_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(time_set_reg))
        else $error("time set flag cleared");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for disciplined_ntp_timestamp_clock
// needs dntc_pkg, dntc_in_if, dntc_out_if and the rtl of the block

module tb_top;
    import dntc_pkg::*;

    localparam int unsigned TICKS_PER_SEC = 1000000;
    localparam int          DIRECTED_ITEMS = 23;
    localparam int          RANDOM_ITEMS = 550;
    localparam int          SETTLE_CYCLES = 80;
    localparam longint      RUN_LIMIT = 4000000;

    // one request item as queued for the driver
    typedef struct {
        func_t              func;
        logic [31:0]        count;
        logic [31:0]        rsec;
        logic [31:0]        rfrac;
        logic signed [31:0] rate;
        bit                 drain;   // hold this item until all readings are back
    } clock_request_t;

    // one predicted response item
    typedef struct {
        logic        time_valid;
        logic [31:0] seconds;
        logic [31:0] fraction;
        logic [63:0] offset;
        logic        accepted;
    } clock_reading_t;

    logic clk;
    logic rst_n;

    dntc_in_if  req_if ();
    dntc_out_if rsp_if ();

    disciplined_ntp_timestamp_clock #(
        .COUNTS_PER_SECOND (TICKS_PER_SEC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    // pending stimulus and outstanding predicted readings
    clock_request_t request_q[$];
    clock_reading_t reading_q[$];

    int issued_count = 0;     // request items accepted by the block
    int returned_count = 0;   // response items taken from the block
    int mismatch_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic calm;               // no idling on either side while set
    clock_request_t next_req;

    // shadow copy of the block state
    bit                 clk_set = 1'b0;
    logic [31:0]        anchor_ticks = '0;
    logic [63:0]        anchor_stamp = '0;
    logic signed [21:0] ppb_corr = '0;

    //------------------------------------------------------------------
    // clock and reset
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver and monitor hold the block inputs quiet during reset
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    //------------------------------------------------------------------
    // prediction
    //------------------------------------------------------------------

    // corrected 32.32 time at a counter sample, from the shadow anchor;
    // ticks go to 2^-32 s units, then scale by 1e9 / (1e9 - ppb), all mod 2^64
    function automatic logic [63:0] corrected_time(input logic [31:0] count);
        logic [31:0]        elapsed;
        logic [63:0]        ticks_q;
        logic signed [63:0] corr_wide;
        logic [63:0]        divisor;
        logic [63:0]        whole;
        logic [63:0]        rest;
        logic [63:0]        scaled;
        elapsed = count - anchor_ticks;
        ticks_q = {elapsed, 32'd0} / 64'(TICKS_PER_SEC);
        corr_wide = ppb_corr;
        divisor = 64'(PPB_SCALE) - corr_wide;
        whole = ticks_q / divisor;
        rest = ticks_q % divisor;
        // whole * 1e9 may wrap; the sum wraps mod 2^64 anyway
        scaled = whole * 64'(PPB_SCALE) + (rest * 64'(PPB_SCALE)) / divisor;
        return anchor_stamp + scaled;
    endfunction

    // apply one accepted item to the shadow state and queue its reading
    task automatic predict_reading(
        input func_t              func,
        input logic [31:0]        count,
        input logic [31:0]        rsec,
        input logic [31:0]        rfrac,
        input logic signed [31:0] rate
    );
        logic [63:0]    now_stamp;
        clock_reading_t want;
        now_stamp = '0;
        want.offset = '0;
        want.accepted = 1'b0;
        case (func)
            FUNC_SET_TIME:
            begin
                clk_set = 1'b1;
                anchor_ticks = count;
                anchor_stamp = {rsec, 32'd0};
                now_stamp = anchor_stamp;
            end
            FUNC_SET_RATE:
            begin
                // rebase with the old correction, then maybe load the new one
                anchor_stamp = corrected_time(count);
                anchor_ticks = count;
                if (rate >= PPB_MIN && rate <= PPB_MAX)
                begin
                    ppb_corr = rate[21:0];
                    want.accepted = 1'b1;
                end
                now_stamp = anchor_stamp;
            end
            default:
            begin
                if (clk_set)
                begin
                    now_stamp = corrected_time(count);
                    if (func == FUNC_GET_OFFSET)
                        want.offset = {rsec, rfrac} - now_stamp;
                end
            end
        endcase
        // nothing but the rate flag shows until time is set
        if (!clk_set)
        begin
            now_stamp = '0;
            want.offset = '0;
        end
        want.time_valid = clk_set;
        want.seconds = now_stamp[63:32];
        want.fraction = now_stamp[31:0];
        reading_q.push_back(want);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    //------------------------------------------------------------------
    // request driver
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.func <= FUNC_SET_TIME;
            req_if.count_now <= '0;
            req_if.ref_seconds <= '0;
            req_if.ref_fraction <= '0;
            req_if.rate_ppb <= '0;
            calm <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // item taken at this edge: predict it and maybe start a gap
            if (req_if.valid && req_if.ready)
            begin
                predict_reading(req_if.func, req_if.count_now, req_if.ref_seconds,
                                req_if.ref_fraction, req_if.rate_ppb);
                issued_count++;
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (request_q.size() > 0 &&
                         !(request_q[0].drain && returned_count != issued_count))
                begin
                    next_req = request_q.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.func <= next_req.func;
                    req_if.count_now <= next_req.count;
                    req_if.ref_seconds <= next_req.rsec;
                    req_if.ref_fraction <= next_req.rfrac;
                    req_if.rate_ppb <= next_req.rate;
                end
                else
                    req_if.valid <= 1'b0;
            end
            // quiet stretch every fourth block of 64 items, and in the tail
            calm <= ((issued_count / 64) % 4 == 3) || (request_q.size() < 60);
        end
    end

    //------------------------------------------------------------------
    // response monitor and ready stalls
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        clock_reading_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (reading_q.size() == 0)
                begin
                    $display("%0t: response item with nothing expected, got %h %h %h %h %h",
                             $time, rsp_if.time_valid, rsp_if.now_seconds,
                             rsp_if.now_fraction, rsp_if.offset, rsp_if.rate_accepted);
                    mismatch_count++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    check_field("time_valid", want.time_valid, rsp_if.time_valid);
                    check_field("now_seconds", want.seconds, rsp_if.now_seconds);
                    check_field("now_fraction", want.fraction, rsp_if.now_fraction);
                    check_field("offset", want.offset, rsp_if.offset);
                    check_field("rate_accepted", want.accepted, rsp_if.rate_accepted);
                end
                returned_count <= returned_count + 1;
            end
            // random bursts of ready stalls
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // stimulus
    //------------------------------------------------------------------
    task automatic add_request(input func_t func, input logic [31:0] count,
                               input logic [31:0] rsec, input logic [31:0] rfrac,
                               input logic signed [31:0] rate, input bit drain);
        clock_request_t item;
        item.func = func;
        item.count = count;
        item.rsec = rsec;
        item.rfrac = rfrac;
        item.rate = rate;
        item.drain = drain;
        request_q.push_back(item);
    endtask

    initial
    begin
        logic [31:0]        sweep_count;
        logic signed [31:0] rate;
        func_t              func;
        int                 pick;

        // reads before time is set stay invalid
        add_request(FUNC_GET_TIME, 32'd0, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_GET_OFFSET, '1, '1, '1, '1, 1'b0);
        // unset time: only the in-range rate is stored and flagged, still invalid
        add_request(FUNC_SET_RATE, 32'd100, 32'd0, 32'd0, PPB_MAX, 1'b0);
        add_request(FUNC_SET_RATE, 32'd200, 32'd0, 32'd0, PPB_MIN - 1, 1'b0);
        add_request(FUNC_GET_TIME, 32'd5000, '1, '1, 32'sd0, 1'b0);
        // anchor at the top of both the counter and the seconds
        add_request(FUNC_SET_TIME, '1, '1, 32'h0, 32'sd0, 1'b0);
        add_request(FUNC_GET_TIME, 32'd0, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_GET_TIME, 32'hFFFF_FFFE, 32'd0, 32'd0, 32'sd0, 1'b0);
        // offsets that wrap both ways
        add_request(FUNC_GET_OFFSET, 32'd1000000, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_GET_OFFSET, 32'd1000000, '1, '1, 32'sd0, 1'b0);
        // both correction limits against the longest elapsed time
        add_request(FUNC_SET_RATE, 32'd123456789, 32'd0, 32'd0, PPB_MIN, 1'b0);
        add_request(FUNC_GET_TIME, 32'd123456788, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_SET_RATE, 32'd0, 32'd0, 32'd0, PPB_MAX, 1'b0);
        add_request(FUNC_GET_OFFSET, '1, 32'h8000_0000, 32'd0, 32'sd0, 1'b0);
        // out-of-range corrections rebase but do not load; then a zero one loads
        add_request(FUNC_SET_RATE, 32'd10, 32'd0, 32'd0, 32'sh7FFF_FFFF, 1'b0);
        add_request(FUNC_SET_RATE, 32'd20, 32'd0, 32'd0, 32'sh8000_0000, 1'b0);
        add_request(FUNC_SET_RATE, 32'd30, 32'd0, 32'd0, PPB_MAX + 1, 1'b0);
        add_request(FUNC_SET_RATE, 32'd40, '1, '1, 32'sd0, 1'b0);
        // re-anchor at zero, fraction of the request is ignored
        add_request(FUNC_SET_TIME, 32'd0, 32'd0, '1, 32'sd0, 1'b0);
        add_request(FUNC_GET_TIME, 32'd0, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_GET_OFFSET, 32'd0, 32'd0, 32'd0, 32'sd0, 1'b0);
        add_request(FUNC_GET_OFFSET, 32'd1000000, 32'h7FFF_FFFF, '1, 32'sd0, 1'b0);
        add_request(FUNC_GET_TIME, 32'd999999, 32'd0, 32'd0, 32'sd0, 1'b0);

        // random part: a counter that mostly moves forward by realistic steps
        sweep_count = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                sweep_count += $urandom_range(0, 2000);
            else if (pick < 16)
                sweep_count += $urandom_range(0, 5000000);
            else if (pick < 19)
                sweep_count += $urandom;
            else
                sweep_count = $urandom;

            pick = $urandom_range(0, 9);
            case (pick)
                0:          func = FUNC_SET_TIME;
                1, 2, 3:    func = FUNC_GET_TIME;
                4, 5, 6:    func = FUNC_GET_OFFSET;
                default:    func = FUNC_SET_RATE;
            endcase

            pick = $urandom_range(0, 9);
            case (pick)
                0:          rate = PPB_MAX;
                1:          rate = PPB_MIN;
                2, 3:       rate = $urandom;
                default:    rate = int'($urandom_range(0, 4000000)) - 2000000;
            endcase

            // a full drain at the start of the random part and midway
            add_request(func, sweep_count, $urandom, $urandom, rate,
                        n == 0 || n == RANDOM_ITEMS / 2);
        end

        // wait for every item to go in and every reading to come back
        while (request_q.size() != 0 || req_if.valid || returned_count != issued_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && reading_q.size() == 0)
            $display("disciplined_ntp_timestamp_clock regression: pass");
        else
            $display("disciplined_ntp_timestamp_clock regression: fail");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #(RUN_LIMIT);
        $display("disciplined_ntp_timestamp_clock regression: fail");
        $finish;
    end

endmodule
